FILE: design/msr_pkg.sv
// shared types and constants for the modular square root unit
package msr_pkg;

  localparam int DATA_W        = 32;
  localparam int MOD_WIDTH_DEF = 32;
  localparam int ZLIMIT        = 1024;

  typedef enum logic [5:0] {
    OP_NONE,
    OP_LOAD,
    OP_RES_ZERO,
    OP_RES_NBIT,
    OP_RES_ACC,
    OP_RES_R,
    OP_POW_N_HALF,
    OP_POW_N_QTR,
    OP_POW_Z_HALF,
    OP_POW_Z_Q,
    OP_POW_N_Q,
    OP_POW_N_QH,
    OP_MUL_ACC,
    OP_MUL_BASE,
    OP_MUL_TT,
    OP_MUL_B,
    OP_MUL_C,
    OP_MUL_T,
    OP_MUL_R,
    OP_EXP_SHIFT,
    OP_QS_INIT,
    OP_QS_STEP,
    OP_Z_INIT,
    OP_Z_INC,
    OP_M_INIT,
    OP_SET_C,
    OP_SET_T,
    OP_SET_R,
    OP_LOOP_INIT,
    OP_I_INC,
    OP_B_INIT,
    OP_J_INC,
    OP_M_SET
  } dp_op_t;

  typedef enum logic [2:0] {
    MD_ACC,
    MD_BASE,
    MD_TT,
    MD_B,
    MD_C,
    MD_T,
    MD_R
  } mul_dst_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHECK,
    S_EULER,
    S_RES_ACC,
    S_QS,
    S_ZCHK,
    S_ZTEST,
    S_PC,
    S_SETC,
    S_PT,
    S_SETT,
    S_PR,
    S_SETR,
    S_LOOP,
    S_INNER,
    S_IINC,
    S_BSQ,
    S_JINC,
    S_CSET,
    S_TSET,
    S_RSET,
    S_FINISH,
    S_POW,
    S_POW_SQ,
    S_POW_SHIFT,
    S_MUL_WAIT
  } state_t;

  typedef struct packed {
    dp_op_t op;
    logic   out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic p_is2;
    logic p_lt2;
    logic p_mod4_3;
    logic acc_is1;
    logic acc_is_pm1;
    logic q_odd;
    logic z_fail;
    logic exp_zero;
    logic exp_lsb;
    logic t_is1;
    logic tt_is1;
    logic i_fail;
    logic j_done;
    logic mul_done;
  } dp_status_t;

endpackage

FILE: design/msr_mulmod.sv
// iterative modular multiplier: one product, then restoring reduction one bit per cycle
module msr_mulmod #(
  parameter int MOD_WIDTH = msr_pkg::MOD_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [MOD_WIDTH-1:0] a,
  input  logic [MOD_WIDTH-1:0] b,
  input  logic [MOD_WIDTH-1:0] m,
  output logic                 done,
  output logic [MOD_WIDTH-1:0] result
);

  localparam int PW = 2 * MOD_WIDTH;
  localparam int CNT_W = $clog2(PW + 1);

  typedef logic [PW-1:0] wide_t;

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  wide_t             prod;
  logic [MOD_WIDTH-1:0] rem;
  logic [MOD_WIDTH:0]   trial;

  assign trial  = {rem, prod[PW-1]};
  assign result = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(PW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod <= wide_t'(a) * wide_t'(b);
      rem  <= '0;
    end else if (busy) begin
      prod <= prod << 1;
      if (trial >= {1'b0, m}) begin
        rem <= MOD_WIDTH'(trial - {1'b0, m});
      end else begin
        rem <= trial[MOD_WIDTH-1:0];
      end
    end
  end

endmodule

FILE: design/msr_datapath.sv
// datapath: operand registers, exponent register, shared modular multiplier, result registers
module msr_datapath #(
  parameter int MOD_WIDTH = msr_pkg::MOD_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [msr_pkg::DATA_W-1:0]  in_value,
  input  logic [msr_pkg::DATA_W-1:0]  in_modulus,
  input  msr_pkg::dp_cmd_t            cmd,
  output msr_pkg::dp_status_t         status,
  output logic [msr_pkg::DATA_W-1:0]  out_data
);

  localparam int W  = MOD_WIDTH;
  localparam int CW = $clog2(MOD_WIDTH + 1);

  logic [W-1:0] n, p, q, z, c, t, r, b, tt, pbase, pexp, pacc, res;
  logic [CW-1:0] s, m, i, j;
  msr_pkg::mul_dst_t mdst;

  logic         mul_start, mul_done;
  logic [W-1:0] mul_a, mul_b, mul_res;
  logic [W:0]   p_inc, q_inc;

  assign p_inc = {1'b0, p} + 1'b1;
  assign q_inc = {1'b0, q} + 1'b1;

  always_comb begin
    mul_start = 1'b1;
    mul_a     = pacc;
    mul_b     = pbase;
    unique case (cmd.op)
      msr_pkg::OP_MUL_ACC:  begin mul_a = pacc;  mul_b = pbase; end
      msr_pkg::OP_MUL_BASE: begin mul_a = pbase; mul_b = pbase; end
      msr_pkg::OP_MUL_TT:   begin mul_a = tt;    mul_b = tt;    end
      msr_pkg::OP_MUL_B:    begin mul_a = b;     mul_b = b;     end
      msr_pkg::OP_MUL_C:    begin mul_a = b;     mul_b = b;     end
      msr_pkg::OP_MUL_T:    begin mul_a = t;     mul_b = c;     end
      msr_pkg::OP_MUL_R:    begin mul_a = r;     mul_b = b;     end
      default:              mul_start = 1'b0;
    endcase
  end

  msr_mulmod #(.MOD_WIDTH(W)) u_mulmod (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .m      (p),
    .done   (mul_done),
    .result (mul_res)
  );

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      msr_pkg::OP_LOAD: begin
        n <= W'(in_value);
        p <= W'(in_modulus);
      end
      msr_pkg::OP_RES_ZERO: res <= '0;
      msr_pkg::OP_RES_NBIT: res <= W'(n[0]);
      msr_pkg::OP_RES_ACC:  res <= pacc;
      msr_pkg::OP_RES_R:    res <= r;
      msr_pkg::OP_POW_N_HALF: begin pbase <= n; pexp <= (p - 1'b1) >> 1; pacc <= W'(1); end
      msr_pkg::OP_POW_N_QTR:  begin pbase <= n; pexp <= W'(p_inc >> 2);  pacc <= W'(1); end
      msr_pkg::OP_POW_Z_HALF: begin pbase <= z; pexp <= (p - 1'b1) >> 1; pacc <= W'(1); end
      msr_pkg::OP_POW_Z_Q:    begin pbase <= z; pexp <= q;               pacc <= W'(1); end
      msr_pkg::OP_POW_N_Q:    begin pbase <= n; pexp <= q;               pacc <= W'(1); end
      msr_pkg::OP_POW_N_QH:   begin pbase <= n; pexp <= W'(q_inc >> 1);  pacc <= W'(1); end
      msr_pkg::OP_MUL_ACC:  mdst <= msr_pkg::MD_ACC;
      msr_pkg::OP_MUL_BASE: mdst <= msr_pkg::MD_BASE;
      msr_pkg::OP_MUL_TT:   mdst <= msr_pkg::MD_TT;
      msr_pkg::OP_MUL_B:    mdst <= msr_pkg::MD_B;
      msr_pkg::OP_MUL_C:    mdst <= msr_pkg::MD_C;
      msr_pkg::OP_MUL_T:    mdst <= msr_pkg::MD_T;
      msr_pkg::OP_MUL_R:    mdst <= msr_pkg::MD_R;
      msr_pkg::OP_EXP_SHIFT: pexp <= pexp >> 1;
      msr_pkg::OP_QS_INIT: begin q <= p - 1'b1; s <= '0; end
      msr_pkg::OP_QS_STEP: begin q <= q >> 1;   s <= s + 1'b1; end
      msr_pkg::OP_Z_INIT:  z <= W'(2);
      msr_pkg::OP_Z_INC:   z <= z + 1'b1;
      msr_pkg::OP_M_INIT:  m <= s;
      msr_pkg::OP_SET_C:   c <= pacc;
      msr_pkg::OP_SET_T:   t <= pacc;
      msr_pkg::OP_SET_R:   r <= pacc;
      msr_pkg::OP_LOOP_INIT: begin i <= '0; tt <= t; end
      msr_pkg::OP_I_INC:   i <= i + 1'b1;
      msr_pkg::OP_B_INIT:  begin b <= c; j <= '0; end
      msr_pkg::OP_J_INC:   j <= j + 1'b1;
      msr_pkg::OP_M_SET:   m <= i;
      default: ;
    endcase

    // multiplier writeback, the controller issues nothing on that cycle
    if (mul_done) begin
      unique case (mdst)
        msr_pkg::MD_ACC:  pacc  <= mul_res;
        msr_pkg::MD_BASE: pbase <= mul_res;
        msr_pkg::MD_TT:   tt    <= mul_res;
        msr_pkg::MD_B:    b     <= mul_res;
        msr_pkg::MD_C:    c     <= mul_res;
        msr_pkg::MD_T:    t     <= mul_res;
        msr_pkg::MD_R:    r     <= mul_res;
        default: ;
      endcase
    end

    if (cmd.out_load) begin
      out_data <= msr_pkg::DATA_W'(res);
    end
  end

  always_comb begin
    status.n_zero     = (n == '0);
    status.p_is2      = (p == W'(2));
    status.p_lt2      = (p < W'(2));
    status.p_mod4_3   = (p[1:0] == 2'b11);
    status.acc_is1    = (pacc == W'(1));
    status.acc_is_pm1 = (pacc == p - 1'b1);
    status.q_odd      = q[0];
    status.z_fail     = (z >= p) || (msr_pkg::DATA_W'(z) > msr_pkg::DATA_W'(msr_pkg::ZLIMIT));
    status.exp_zero   = (pexp == '0);
    status.exp_lsb    = pexp[0];
    status.t_is1      = (t == W'(1));
    status.tt_is1     = (tt == W'(1));
    status.i_fail     = ({1'b0, i} + 1'b1) >= {1'b0, m};
    status.j_done     = ({1'b0, j} + {1'b0, i} + 1'b1) >= {1'b0, m};
    status.mul_done   = mul_done;
  end

endmodule

FILE: design/msr_ctrl.sv
// controller: sequences exponentiations, non-residue search and the shanks loop
module msr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  msr_pkg::dp_status_t status,
  output msr_pkg::dp_cmd_t    cmd
);

  msr_pkg::state_t state, state_next;
  msr_pkg::state_t pret, pret_next;
  msr_pkg::state_t mret, mret_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= msr_pkg::S_IDLE;
      pret      <= msr_pkg::S_IDLE;
      mret      <= msr_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      pret  <= pret_next;
      mret  <= mret_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next   = state;
    pret_next    = pret;
    mret_next    = mret;
    cmd.op       = msr_pkg::OP_NONE;
    cmd.out_load = 1'b0;
    in_ready     = 1'b0;
    unique case (state)
      msr_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = msr_pkg::OP_LOAD;
          state_next = msr_pkg::S_CHECK;
        end
      end
      msr_pkg::S_CHECK: begin
        state_next = msr_pkg::S_FINISH;
        if (status.n_zero || status.p_lt2) begin
          cmd.op = msr_pkg::OP_RES_ZERO;
        end else if (status.p_is2) begin
          cmd.op = msr_pkg::OP_RES_NBIT;
        end else begin
          cmd.op     = msr_pkg::OP_POW_N_HALF;
          pret_next  = msr_pkg::S_EULER;
          state_next = msr_pkg::S_POW;
        end
      end
      msr_pkg::S_EULER: begin
        if (!status.acc_is1) begin
          cmd.op     = msr_pkg::OP_RES_ZERO;
          state_next = msr_pkg::S_FINISH;
        end else if (status.p_mod4_3) begin
          cmd.op     = msr_pkg::OP_POW_N_QTR;
          pret_next  = msr_pkg::S_RES_ACC;
          state_next = msr_pkg::S_POW;
        end else begin
          cmd.op     = msr_pkg::OP_QS_INIT;
          state_next = msr_pkg::S_QS;
        end
      end
      msr_pkg::S_RES_ACC: begin
        cmd.op     = msr_pkg::OP_RES_ACC;
        state_next = msr_pkg::S_FINISH;
      end
      msr_pkg::S_QS: begin
        if (status.q_odd) begin
          cmd.op     = msr_pkg::OP_Z_INIT;
          state_next = msr_pkg::S_ZCHK;
        end else begin
          cmd.op = msr_pkg::OP_QS_STEP;
        end
      end
      msr_pkg::S_ZCHK: begin
        if (status.z_fail) begin
          cmd.op     = msr_pkg::OP_RES_ZERO;
          state_next = msr_pkg::S_FINISH;
        end else begin
          cmd.op     = msr_pkg::OP_POW_Z_HALF;
          pret_next  = msr_pkg::S_ZTEST;
          state_next = msr_pkg::S_POW;
        end
      end
      msr_pkg::S_ZTEST: begin
        if (status.acc_is_pm1) begin
          cmd.op     = msr_pkg::OP_M_INIT;
          state_next = msr_pkg::S_PC;
        end else begin
          cmd.op     = msr_pkg::OP_Z_INC;
          state_next = msr_pkg::S_ZCHK;
        end
      end
      msr_pkg::S_PC: begin
        cmd.op     = msr_pkg::OP_POW_Z_Q;
        pret_next  = msr_pkg::S_SETC;
        state_next = msr_pkg::S_POW;
      end
      msr_pkg::S_SETC: begin
        cmd.op     = msr_pkg::OP_SET_C;
        state_next = msr_pkg::S_PT;
      end
      msr_pkg::S_PT: begin
        cmd.op     = msr_pkg::OP_POW_N_Q;
        pret_next  = msr_pkg::S_SETT;
        state_next = msr_pkg::S_POW;
      end
      msr_pkg::S_SETT: begin
        cmd.op     = msr_pkg::OP_SET_T;
        state_next = msr_pkg::S_PR;
      end
      msr_pkg::S_PR: begin
        cmd.op     = msr_pkg::OP_POW_N_QH;
        pret_next  = msr_pkg::S_SETR;
        state_next = msr_pkg::S_POW;
      end
      msr_pkg::S_SETR: begin
        cmd.op     = msr_pkg::OP_SET_R;
        state_next = msr_pkg::S_LOOP;
      end
      msr_pkg::S_LOOP: begin
        if (status.t_is1) begin
          cmd.op     = msr_pkg::OP_RES_R;
          state_next = msr_pkg::S_FINISH;
        end else begin
          cmd.op     = msr_pkg::OP_LOOP_INIT;
          state_next = msr_pkg::S_INNER;
        end
      end
      msr_pkg::S_INNER: begin
        if (status.tt_is1) begin
          cmd.op     = msr_pkg::OP_B_INIT;
          state_next = msr_pkg::S_BSQ;
        end else if (status.i_fail) begin
          cmd.op     = msr_pkg::OP_RES_ZERO;
          state_next = msr_pkg::S_FINISH;
        end else begin
          cmd.op     = msr_pkg::OP_MUL_TT;
          mret_next  = msr_pkg::S_IINC;
          state_next = msr_pkg::S_MUL_WAIT;
        end
      end
      msr_pkg::S_IINC: begin
        cmd.op     = msr_pkg::OP_I_INC;
        state_next = msr_pkg::S_INNER;
      end
      msr_pkg::S_BSQ: begin
        if (status.j_done) begin
          cmd.op     = msr_pkg::OP_M_SET;
          state_next = msr_pkg::S_CSET;
        end else begin
          cmd.op     = msr_pkg::OP_MUL_B;
          mret_next  = msr_pkg::S_JINC;
          state_next = msr_pkg::S_MUL_WAIT;
        end
      end
      msr_pkg::S_JINC: begin
        cmd.op     = msr_pkg::OP_J_INC;
        state_next = msr_pkg::S_BSQ;
      end
      msr_pkg::S_CSET: begin
        cmd.op     = msr_pkg::OP_MUL_C;
        mret_next  = msr_pkg::S_TSET;
        state_next = msr_pkg::S_MUL_WAIT;
      end
      msr_pkg::S_TSET: begin
        cmd.op     = msr_pkg::OP_MUL_T;
        mret_next  = msr_pkg::S_RSET;
        state_next = msr_pkg::S_MUL_WAIT;
      end
      msr_pkg::S_RSET: begin
        cmd.op     = msr_pkg::OP_MUL_R;
        mret_next  = msr_pkg::S_LOOP;
        state_next = msr_pkg::S_MUL_WAIT;
      end
      msr_pkg::S_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = msr_pkg::S_IDLE;
        end
      end
      msr_pkg::S_POW: begin
        if (status.exp_zero) begin
          state_next = pret;
        end else if (status.exp_lsb) begin
          cmd.op     = msr_pkg::OP_MUL_ACC;
          mret_next  = msr_pkg::S_POW_SQ;
          state_next = msr_pkg::S_MUL_WAIT;
        end else begin
          state_next = msr_pkg::S_POW_SQ;
        end
      end
      msr_pkg::S_POW_SQ: begin
        cmd.op     = msr_pkg::OP_MUL_BASE;
        mret_next  = msr_pkg::S_POW_SHIFT;
        state_next = msr_pkg::S_MUL_WAIT;
      end
      msr_pkg::S_POW_SHIFT: begin
        cmd.op     = msr_pkg::OP_EXP_SHIFT;
        state_next = msr_pkg::S_POW;
      end
      msr_pkg::S_MUL_WAIT: begin
        if (status.mul_done) begin
          state_next = mret;
        end
      end
      default: state_next = msr_pkg::S_IDLE;
    endcase
  end

endmodule

FILE: design/modular_square_root_unit.sv
// top level of the tonelli-shanks modular square root unit
//
// usage:
//   s_axis carries one transaction per request: value_in and modulus, which
//   must be two or an odd prime. m_axis returns one transaction per request
//   with the root in 0..p-1, or zero when none exists or value_in is zero.
//   both inputs are cut to MOD_WIDTH bits before use.
// pacing:
//   one request at a time. every modular multiply runs on the single shared
//   multiplier (a product step, then one reduction bit per cycle), and that
//   unit sets the pace. a p = 3 mod 4 request takes two exponentiations,
//   about 4 * MOD_WIDTH multiplies at worst; p = 1 mod 4 adds the
//   non-residue search, one more exponentiation per candidate z, and the
//   shanks loop, so each further candidate z lengthens a request. trivial
//   cases (zero value, modulus two or below) pass through the check and
//   finish states only, and intake reopens in the same cycle as the root
//   appears.
// reset: rst is synchronous and active high; it returns the controller to
//   idle and drops m_axis_tvalid. no clearing pass is needed.
// stall: a finished root sits in the output register; s_axis_tready rises
//   again right away, and a later root waits in the controller until the
//   output register has been taken.
module modular_square_root_unit #(
  parameter int MOD_WIDTH = msr_pkg::MOD_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] value_in, [63:32] modulus
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [31:0] root
);

  msr_pkg::dp_cmd_t    cmd;
  msr_pkg::dp_status_t status;

  // controller: state machine plus output valid flag
  msr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath: operands, exponent, multiplier and the output register
  msr_datapath #(.MOD_WIDTH(MOD_WIDTH)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_value   (s_axis_tdata[31:0]),
    .in_modulus (s_axis_tdata[63:32]),
    .cmd        (cmd),
    .status     (status),
    .out_data   (m_axis_tdata)
  );

  // one request at a time: intake closes right after a transaction
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second request accepted while one is in flight");

  // a new root never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("output register loaded while holding an untaken root");

  // loading the output register always presents a transaction
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> m_axis_tvalid)
    else $error("output loaded without raising valid");

  // a multiply never completes while intake is open
  a_mul_idle: assert property (@(posedge clk) disable iff (rst)
    status.mul_done |-> !s_axis_tready)
    else $error("multiplier active while idle");

endmodule

FILE: sim/modular_square_root_unit_tb.sv
// testbench for the modular square root unit: directed and random roots checked against a local predictor
`timescale 1ns / 100ps

module modular_square_root_unit_tb;

  typedef struct {
    logic [31:0] value;
    logic [31:0] modulus;
    logic [31:0] root;
  } root_req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;   // [31:0] value_in, [63:32] modulus
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [31:0] root

  root_req_t pending_roots[$];
  int        error_count = 0;
  bit        idle_on = 1'b0;
  int        stall_left = 0;

  modular_square_root_unit dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // safety net against a hung controller
  initial begin
    #500000000;
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // predictor: tonelli-shanks on 64-bit integers
  // ---------------------------------------------------------------------------
  function automatic longint unsigned pow_mod(longint unsigned b, longint unsigned e,
                                              longint unsigned m);
    longint unsigned r;
    r = 1 % m;
    b = b % m;
    while (e != 0) begin
      if (e[0]) r = (r * b) % m;
      b = (b * b) % m;
      e = e >> 1;
    end
    return r;
  endfunction

  function automatic logic [31:0] predict_root(logic [31:0] value, logic [31:0] modulus);
    longint unsigned n, p, q, s, z, c, t, r, m, i, tt, b, j;
    n = value;
    p = modulus;
    if (n == 0) return 32'd0;
    if (p == 2) return {31'd0, value[0]};
    if (p < 2) return 32'd0;
    if (pow_mod(n, (p - 1) / 2, p) != 1) return 32'd0;
    if (p % 4 == 3) return 32'(pow_mod(n, (p + 1) / 4, p));
    q = p - 1;
    s = 0;
    while (q[0] == 1'b0) begin
      q = q >> 1;
      s++;
    end
    // non-residue search upward from two, bounded like the hardware
    z = 2;
    forever begin
      if (z >= p || z > msr_pkg::ZLIMIT) return 32'd0;
      if (pow_mod(z, (p - 1) / 2, p) == p - 1) break;
      z++;
    end
    m = s;
    c = pow_mod(z, q, p);
    t = pow_mod(n, q, p);
    r = pow_mod(n, (q + 1) / 2, p);
    forever begin
      if (t == 1) return 32'(r);
      i = 0;
      tt = t;
      while (tt != 1) begin
        // composite modulus can make t refuse to square down to one
        if (i + 1 >= m) return 32'd0;
        tt = (tt * tt) % p;
        i++;
      end
      b = c;
      for (j = 0; j + i + 1 < m; j++) b = (b * b) % p;
      m = i;
      c = (b * b) % p;
      t = (t * c) % p;
      r = (r * b) % p;
    end
  endfunction

  function automatic bit is_prime(longint unsigned v);
    longint unsigned d;
    if (v < 2) return 1'b0;
    if (v < 4) return 1'b1;
    if (v[0] == 1'b0) return 1'b0;
    for (d = 3; d * d <= v; d += 2)
      if (v % d == 0) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [31:0] pick_prime(logic [31:0] lo, logic [31:0] hi);
    logic [31:0] v;
    do v = $urandom_range(hi, lo); while (!is_prime(v));
    return v;
  endfunction

  // a quadratic residue lifted by a random multiple of p so the high bits move too
  function automatic logic [31:0] pick_square(logic [31:0] modulus);
    longint unsigned x, sq, k_max;
    x = $urandom;
    sq = (x * x) % modulus;
    k_max = (64'hFFFF_FFFF - sq) / modulus;
    if (k_max > 64'hFFFF_FFFF) k_max = 64'hFFFF_FFFF;
    return 32'(sq + longint'(modulus) * $urandom_range(32'(k_max), 0));
  endfunction

  // ---------------------------------------------------------------------------
  // shared sender: one transaction per call, optional random gap first
  // ---------------------------------------------------------------------------
  task automatic send_item(logic [31:0] value, logic [31:0] modulus);
    root_req_t req;
    int gap;
    gap = (idle_on && $urandom_range(3, 0) == 0) ? $urandom_range(7, 1) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {modulus, value};
    req.value   = value;
    req.modulus = modulus;
    req.root    = predict_root(value, modulus);
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_roots.push_back(req);
  endtask

  // drop valid so the last transaction is not taken twice, then wait for all roots
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_roots.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stall bursts and the scoreboard
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= (stall_left == 1);
    end else if (idle_on && $urandom_range(4, 0) == 0) begin
      stall_left    <= $urandom_range(7, 1);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    root_req_t req;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_roots.size() == 0) begin
        $display("%0t: unexpected root transaction, actual %h", $time, m_axis_tdata);
        error_count++;
      end else begin
        req = pending_roots.pop_front();
        if (m_axis_tdata !== req.root) begin
          $display("%0t: root mismatch n=%h p=%h expected %h actual %h",
                   $time, req.value, req.modulus, req.root, m_axis_tdata);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // zero value, modulus two, modulus zero and one
  task automatic test_trivial_cases();
    send_item(32'd0, 32'd7);
    send_item(32'd0, 32'hFFFF_FFFB);
    send_item(32'hFFFF_FFFF, 32'd2);
    send_item(32'hFFFF_FFFE, 32'd2);
    send_item(32'd5, 32'd0);
    send_item(32'hFFFF_FFFF, 32'd1);
  endtask

  // p = 3 mod 4: direct exponentiation, non-residues and multiples of p
  task automatic test_fast_exponent();
    send_item(32'd2, 32'd7);
    send_item(32'd3, 32'd7);          // non-residue
    send_item(32'd21, 32'd7);         // multiple of p
    send_item(32'hFFFF_FFFF, 32'd3);
    send_item(pick_square(32'hFFFF_FFFB), 32'hFFFF_FFFB);
    send_item(32'hFFFF_FFFA, 32'hFFFF_FFFB);
  endtask

  // p = 1 mod 4: non-residue search and the shanks loop, deep two-adic primes too
  task automatic test_shanks_loop();
    send_item(32'd4, 32'd5);
    send_item(32'd2, 32'd13);         // non-residue
    send_item(pick_square(32'd257), 32'd257);
    send_item(pick_square(32'd65537), 32'd65537);
    // hold off until the unit is empty before the slowest case
    wait_drained();
    send_item(pick_square(32'hC000_0001), 32'hC000_0001);
    send_item(pick_square(32'd97), 32'd97);
  endtask

  // moduli outside the prime contract still have defined results
  task automatic test_odd_moduli();
    send_item(32'd1, 32'd4);
    send_item(32'd7, 32'd6);
    send_item(32'h1234_5679, 32'hFFFF_FFFE);
    send_item(32'd4, 32'd15);
    send_item(32'd7, 32'd9);
    send_item(32'd16, 32'd21);
  endtask

  task automatic test_random_roots(int count, int calm_tail);
    logic [31:0] p, n;
    int sel;
    for (int k = 0; k < count; k++) begin
      idle_on = (k < count - calm_tail);
      sel = $urandom_range(99, 0);
      if (sel < 70)      p = pick_prime(32'd3, 32'd1023);
      else if (sel < 80) p = pick_prime(32'd1024, 32'd65535);
      else if (sel < 85) p = pick_prime(32'h8000_0000, 32'hFFFF_FFFF);
      else if (sel < 90) p = $urandom_range(2, 0);
      else if (sel < 95) p = {31'($urandom_range(511, 2)), 1'b0};
      else               p = {31'($urandom_range(511, 4)), 1'b1};
      if (p >= 3 && $urandom_range(3, 0) != 0) n = pick_square(p);
      else n = $urandom;
      send_item(n, p);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    idle_on = 1'b1;
    test_trivial_cases();
    test_fast_exponent();
    test_shanks_loop();
    test_odd_moduli();
    test_random_roots(280, 40);
    wait_drained();
    repeat (100) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
